>>> hw/rtl/flsa_pkg.sv
// Package for the free-list slot allocator: field widths, register indexes,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package flsa_pkg;

	localparam int COUNT_W    = 7;
	localparam int WORDS_W    = 7;
	localparam int ADDR_W     = 32;
	localparam int IDX_W      = 6;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_WORDS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic clear_restart;
		logic clear_step;
		logic capture;
		logic exec;
	} flsa_cmd_t;

	typedef struct packed {
		logic cfg_hit;
		logic clear_last;
	} flsa_stat_t;

endpackage

>>> hw/rtl/flsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module flsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/flsa_datapath.sv
// Datapath of the slot allocator: config registers, head and free count,
// next-link RAM with its clearing counter, and the result register.
// Depends on flsa_pkg and flsa_ram.
`timescale 1ns / 1ps

module flsa_datapath #(
	parameter int POOL_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [flsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [flsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_op,
	input  logic [flsa_pkg::IDX_W-1:0]        in_idx,
	input  flsa_pkg::flsa_cmd_t               cmd,
	output flsa_pkg::flsa_stat_t              stat,
	output logic [flsa_pkg::OUT_DATA_W-1:0]   out_data
);

	import flsa_pkg::*;

	localparam int AW   = $clog2(POOL_DEPTH);
	localparam int LW   = $clog2(POOL_DEPTH + 1);
	localparam int CMPW = (LW > COUNT_W) ? LW : COUNT_W;

	logic [COUNT_W-1:0] slot_count_q;
	logic [WORDS_W-1:0] slot_words_q;
	logic [ADDR_W-1:0]  base_q;
	logic [LW-1:0]      head_q;
	logic [COUNT_W-1:0] free_q;
	logic [AW-1:0]      clr_q;
	logic               op_q;
	logic [IDX_W-1:0]   idx_q;

	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    gidx_q;
	logic [ADDR_W-1:0]   gaddr_q;
	logic [COUNT_W-1:0]  fcnt_q;
	logic                all_free_q;

	logic [COUNT_W-1:0]    n_eff;
	logic [LW-1:0]         link_rdata;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [LW-1:0]         mem_wdata;
	logic [LW+WORDS_W-1:0] prod;
	logic                  alloc_ok;
	logic                  free_ok;
	status_t               status_n;
	logic [IDX_W-1:0]      gidx_n;
	logic [ADDR_W-1:0]     gaddr_n;
	logic [LW-1:0]         head_n;
	logic [COUNT_W-1:0]    free_n;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= COUNT_W'(64);
			slot_words_q <= WORDS_W'(1);
			base_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_COUNT:   slot_count_q <= cfg_data[COUNT_W-1:0];
				REG_SLOT_WORDS:   slot_words_q <= cfg_data[WORDS_W-1:0];
				REG_BASE_ADDRESS: base_q       <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign stat.cfg_hit = cfg_we && (cfg_index == REG_SLOT_COUNT ||
		cfg_index == REG_SLOT_WORDS || cfg_index == REG_BASE_ADDRESS);
	assign stat.clear_last = (clr_q == AW'(POOL_DEPTH - 1));

	always_comb begin
		if (slot_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (int'(slot_count_q) > POOL_DEPTH) begin
			n_eff = COUNT_W'(POOL_DEPTH);
		end else begin
			n_eff = slot_count_q;
		end
	end

	// operation
	assign prod     = (LW+WORDS_W)'(head_q) * (LW+WORDS_W)'(slot_words_q);
	assign alloc_ok = (free_q != '0) && (CMPW'(head_q) < CMPW'(n_eff));
	assign free_ok  = (COUNT_W'(idx_q) < n_eff);

	always_comb begin
		status_n = ST_OK;
		gidx_n   = '0;
		gaddr_n  = '0;
		head_n   = head_q;
		free_n   = free_q;
		if (op_q == OP_ALLOC) begin
			if (alloc_ok) begin
				gidx_n  = head_q[IDX_W-1:0];
				gaddr_n = base_q + ADDR_W'(prod);
				head_n  = link_rdata;
				free_n  = free_q - COUNT_W'(1);
			end else begin
				status_n = ST_EMPTY;
			end
		end else begin
			if (free_ok) begin
				head_n = LW'(idx_q);
				if (free_q < COUNT_MAX) begin
					free_n = free_q + COUNT_W'(1);
				end
			end else begin
				status_n = ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			free_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clear_restart) begin
				clr_q <= '0;
			end else if (cmd.clear_step) begin
				clr_q  <= clr_q + AW'(1);
				head_q <= '0;
				free_q <= n_eff;
			end else if (cmd.exec) begin
				head_q <= head_n;
				free_q <= free_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			idx_q <= in_idx;
		end
		if (cmd.exec) begin
			status_q   <= status_n;
			gidx_q     <= gidx_n;
			gaddr_q    <= gaddr_n;
			fcnt_q     <= free_n;
			all_free_q <= (free_n >= n_eff);
		end
	end

	// link RAM: clearing pass writes i+1, a good free writes the old head
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = LW'(clr_q) + LW'(1);
		if (cmd.clear_step) begin
			mem_we = 1'b1;
		end else if (cmd.exec && op_q == OP_FREE && free_ok) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(idx_q);
			mem_wdata = head_q;
		end
	end

	flsa_ram #(
		.WIDTH(LW),
		.DEPTH(POOL_DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(head_q[AW-1:0]),
		.rdata(link_rdata)
	);

	assign out_data = {all_free_q, fcnt_q, gaddr_q, gidx_q, status_q};

`ifndef SYNTHESIS
	a_clear_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |=> (head_q == '0 && free_q == $past(n_eff)))
		else $error("clear step did not rebuild head and count");
	a_alloc_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_ALLOC && alloc_ok) |=>
		(free_q == $past(free_q) - COUNT_W'(1)))
		else $error("alloc did not decrement free count");
	a_bad_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && status_n != ST_OK) |=> (head_q == $past(head_q) && $stable(free_q)))
		else $error("rejected request changed list state");
`endif

endmodule

>>> hw/rtl/flsa_ctrl.sv
// Controller of the slot allocator: clearing pass, request capture, execute
// and the output valid flag.
// Depends on flsa_pkg.
`timescale 1ns / 1ps

module flsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  flsa_pkg::flsa_stat_t stat,
	output flsa_pkg::flsa_cmd_t  cmd
);

	import flsa_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	assign cmd.clear_restart = stat.cfg_hit;
	assign cmd.clear_step    = (state_q == S_CLEAR) && !stat.cfg_hit;
	assign cmd.capture       = s_tvalid && s_tready;
	assign cmd.exec          = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (stat.cfg_hit) begin
				state_q <= S_CLEAR;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						if (stat.clear_last) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (cmd.capture) begin
							state_q <= S_EXEC;
						end
					end
					S_EXEC: begin
						if (cmd.exec) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_CLEAR;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && !stat.cfg_hit) |=> (state_q == S_EXEC))
		else $error("captured request not executed");
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cfg_hit |=> (state_q == S_CLEAR && !s_tready))
		else $error("config write did not start clearing pass");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.exec))
		else $error("result appeared without execute");
`endif

endmodule

>>> hw/rtl/free_list_slot_allocator.sv
// Fixed-size slot allocator over a linked free list held in RAM.
// Usage: requests enter on the s_ stream: s_tuser is the op (0 allocate,
// 1 free), s_tdata[5:0] the slot index to free. Each request gives one
// result on the m_ stream.
// Configuration: cfg_we/cfg_index/cfg_data write slot_count (0), slot_words
// (1) or base_address (2); each such write rebuilds the free list.
// Flow: a request is accepted, then executed against the registered read of
// the head's next link into the output register; the next request is accepted
// only once the previous one has executed.
// Reset and every configuration write start a clearing pass over all POOL_DEPTH
// link entries that writes the in-order links; s_tready stays low during it.
// When the receiver stalls, the result is held in the output register; the
// next request is still accepted and waits in execute until the register
// is taken.
// Depends on flsa_pkg, flsa_ctrl, flsa_datapath, flsa_ram.
`timescale 1ns / 1ps

module free_list_slot_allocator #(
	parameter int POOL_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [flsa_pkg::IN_DATA_W-1:0]  s_tdata,  // [5:0] slot_index, [7:6] zero
	input  logic                            s_tuser,  // [0] op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] status, [7:2] granted_index, [39:8] granted_address,
	// [46:40] free_count, [47] all_free
	output logic [flsa_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [flsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [flsa_pkg::CFG_DATA_W-1:0] cfg_data
);

	import flsa_pkg::*;

	flsa_cmd_t  cmd;
	flsa_stat_t stat;

	flsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	flsa_datapath #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_op    (s_tuser),
		.in_idx   (s_tdata[IDX_W-1:0]),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (m_tdata)
	);

endmodule

>>> test/tb_top.sv
// Self-checking bench for free_list_slot_allocator: drives alloc/free requests on the
// s_ stream, predicts grants from a local free-list model or fixed expected values and checks the m_ stream.
// Depends on flsa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_top;
	import flsa_pkg::*;

	localparam int RANDOM_REQUESTS = 1200;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int LONG_STALL      = 60;
	localparam int DEPTH           = 64;

	// same bit order as m_tdata
	typedef struct packed {
		logic              all_free;
		logic [COUNT_W-1:0] free_count;
		logic [ADDR_W-1:0]  address;
		logic [IDX_W-1:0]   index;
		status_t            status;
	} grant_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  sel;
		logic [CFG_DATA_W-1:0] value;
		logic                  op;
		logic [IDX_W-1:0]      idx;
		bit                    typed;
		grant_t                want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// local copy of the pool
	logic [COUNT_W-1:0] link_mem [DEPTH];
	logic [COUNT_W-1:0] head_q;
	logic [COUNT_W-1:0] free_q;
	logic [COUNT_W-1:0] count_reg;
	logic [WORDS_W-1:0] words_reg;
	logic [ADDR_W-1:0]  base_reg;

	grant_t    grant_queue[$];
	plan_row_t plan_rows[$];
	int        held[$];
	int        errors;
	int        cycles;
	int        burst_left;
	bit        gaps_on;
	int        stall_asks;

	free_list_slot_allocator #(.POOL_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [COUNT_W-1:0] pool_span();
		if (count_reg == 0)
			return COUNT_W'(1);
		if (count_reg > DEPTH)
			return COUNT_W'(DEPTH);
		return count_reg;
	endfunction

	function automatic void pool_rebuild();
		for (int i = 0; i < DEPTH; i++)
			link_mem[i] = COUNT_W'(i + 1);
		head_q = '0;
		free_q = pool_span();
	endfunction

	function automatic grant_t pool_apply(logic op, logic [IDX_W-1:0] idx);
		grant_t             g;
		logic [COUNT_W-1:0] n;
		n = pool_span();
		g = '0;
		g.status = ST_OK;
		if (op == OP_ALLOC) begin
			if (free_q == 0 || head_q >= n) begin
				g.status = ST_EMPTY;
			end else begin
				g.index = head_q[IDX_W-1:0];
				g.address = base_reg + 32'(head_q) * 32'(words_reg);
				head_q = link_mem[head_q[IDX_W-1:0]];
				free_q = free_q - COUNT_W'(1);
			end
		end else if ({1'b0, idx} >= n) begin
			g.status = ST_RANGE;
		end else begin
			link_mem[idx] = head_q;
			head_q = {1'b0, idx};
			if (free_q < COUNT_MAX)
				free_q = free_q + COUNT_W'(1);
		end
		g.free_count = free_q;
		g.all_free = (free_q >= n);
		return g;
	endfunction

	function automatic grant_t make_grant(status_t st, int idx, logic [ADDR_W-1:0] addr,
			int cnt, bit af);
		grant_t g;
		g.status = st;
		g.index = IDX_W'(idx);
		g.address = addr;
		g.free_count = COUNT_W'(cnt);
		g.all_free = af;
		return g;
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] v);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.sel = sel;
		row.value = v;
		plan_rows.push_back(row);
	endfunction

	function automatic void add_req(logic op, int idx, bit typed, grant_t want);
		plan_row_t row;
		row = '{default: '0};
		row.op = op;
		row.idx = IDX_W'(idx);
		row.typed = typed;
		row.want = want;
		plan_rows.push_back(row);
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 25)
				$display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		grant_t want;
		grant_t seen;
		if (m_tvalid && m_tready) begin
			seen = m_tdata;
			if (grant_queue.size() == 0) begin
				errors++;
				if (errors <= 25)
					$display("%0t ns: unexpected result, expected none got %0h", $time, m_tdata);
			end else begin
				want = grant_queue.pop_front();
				check_field("status", 32'(want.status), 32'(seen.status));
				check_field("granted_index", 32'(want.index), 32'(seen.index));
				check_field("granted_address", want.address, seen.address);
				check_field("free_count", 32'(want.free_count), 32'(seen.free_count));
				check_field("all_free", 32'(want.all_free), 32'(seen.all_free));
			end
		end
	end

	// receiver: changing ready patterns, plus long hold-offs on request
	initial begin
		int mode;
		int left;
		int served;
		int tick;
		mode = 0;
		left = 0;
		served = 0;
		tick = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (served != stall_asks) begin
				served = stall_asks;
				m_tready <= 1'b0;
				repeat (LONG_STALL - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				tick++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	task automatic send_request(input logic op, input logic [IDX_W-1:0] idx, input bit typed,
			input grant_t fixed, output grant_t got);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_DATA_W - IDX_W){1'b0}}, idx};
		do @(posedge clk); while (!s_tready);
		got = pool_apply(op, idx);
		grant_queue.push_back(typed ? fixed : got);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (grant_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] v);
		wait_drained();
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_SLOT_COUNT: count_reg = v[COUNT_W-1:0];
			REG_SLOT_WORDS: words_reg = v[WORDS_W-1:0];
			default: base_reg = v;
		endcase
		pool_rebuild();
		held.delete();
	endtask

	initial begin
		grant_t             got;
		logic               op;
		logic [IDX_W-1:0]   idx;
		logic [COUNT_W-1:0] cnt;
		int                 sent;
		int                 phase;
		int                 len;
		int                 alloc_pct;
		int                 j;
		bit                 storm;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		stall_asks = 0;
		count_reg = 7'd64;
		words_reg = 7'd1;
		base_reg = '0;
		pool_rebuild();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// defaults: 64 slots, 1 word, base 0
		add_req(OP_ALLOC, 0, 1, make_grant(ST_OK, 0, 0, 63, 0));
		add_req(OP_FREE, 0, 1, make_grant(ST_OK, 0, 0, 64, 1));
		add_req(OP_FREE, 63, 1, make_grant(ST_OK, 0, 0, 65, 1));  // double free
		add_req(OP_ALLOC, 0, 0, '0);
		// count 0 acts as 1, zero-word slots
		add_write(REG_SLOT_COUNT, 32'h0000_0F00);
		add_write(REG_SLOT_WORDS, 32'h0);
		add_write(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
		add_req(OP_ALLOC, 63, 1, make_grant(ST_OK, 0, 32'hFFFF_FFF0, 0, 0));
		add_req(OP_ALLOC, 0, 1, make_grant(ST_EMPTY, 0, 0, 0, 0));
		add_req(OP_FREE, 1, 1, make_grant(ST_RANGE, 0, 0, 0, 0));
		add_req(OP_FREE, 63, 1, make_grant(ST_RANGE, 0, 0, 0, 0));
		add_req(OP_FREE, 0, 1, make_grant(ST_OK, 0, 0, 1, 1));
		// count above the pool saturates, address wraps
		add_write(REG_SLOT_COUNT, 32'd127);
		add_write(REG_SLOT_WORDS, 32'd127);
		add_write(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
		add_req(OP_ALLOC, 0, 1, make_grant(ST_OK, 0, 32'hFFFF_FFFF, 63, 0));
		add_req(OP_ALLOC, 0, 1, make_grant(ST_OK, 1, 32'h0000_007E, 62, 0));
		add_req(OP_FREE, 63, 0, '0);
		add_req(OP_ALLOC, 0, 0, '0);
		add_req(OP_ALLOC, 0, 0, '0);
		// two slots: empty pool, bad index, cyclic list after double frees
		add_write(REG_SLOT_COUNT, 32'd2);
		add_write(REG_SLOT_WORDS, 32'd64);
		add_write(REG_BASE_ADDRESS, 32'h0000_1000);
		add_req(OP_ALLOC, 0, 1, make_grant(ST_OK, 0, 32'h0000_1000, 1, 0));
		add_req(OP_ALLOC, 0, 1, make_grant(ST_OK, 1, 32'h0000_1040, 0, 0));
		add_req(OP_ALLOC, 0, 1, make_grant(ST_EMPTY, 0, 0, 0, 0));
		add_req(OP_FREE, 2, 1, make_grant(ST_RANGE, 0, 0, 0, 0));
		for (int i = 0; i < 3; i++)
			add_req(OP_FREE, 1, 0, '0);
		for (int i = 0; i < 4; i++)
			add_req(OP_ALLOC, 0, 0, '0);

		foreach (plan_rows[i]) begin
			if (plan_rows[i].is_cfg)
				write_register(plan_rows[i].sel, plan_rows[i].value);
			else
				send_request(plan_rows[i].op, plan_rows[i].idx, plan_rows[i].typed,
					plan_rows[i].want, got);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_REQUESTS) begin
			if (phase == 0 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0, 1: cnt = COUNT_W'($urandom_range(1, 8));
					2: cnt = COUNT_W'($urandom_range(9, 64));
					3: cnt = 7'd64;
					4: cnt = 7'd0;
					default: cnt = COUNT_W'($urandom_range(65, 127));
				endcase
				write_register(REG_SLOT_COUNT, ($urandom() & ~32'h7F) | 32'(cnt));
			end
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: cnt = 7'd0;
					1: cnt = 7'd1;
					2: cnt = 7'd64;
					3: cnt = 7'd127;
					default: cnt = COUNT_W'($urandom_range(0, 127));
				endcase
				write_register(REG_SLOT_WORDS, ($urandom() & ~32'h7F) | 32'(cnt));
			end
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: write_register(REG_BASE_ADDRESS, 32'h0);
					1: write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
					default: write_register(REG_BASE_ADDRESS, $urandom());
				endcase
			end

			gaps_on = ($urandom_range(0, 3) != 0);
			alloc_pct = $urandom_range(25, 75);
			storm = (phase == 2);
			len = storm ? 150 : $urandom_range(40, 150);
			for (int k = 0; k < len && sent < RANDOM_REQUESTS; k++) begin
				if (phase == 1 && k == 10)
					stall_asks++;
				if (phase == 3 && k == len / 2)
					wait_drained();
				if (storm) begin
					// free counter runs into saturation
					op = OP_FREE;
					idx = IDX_W'($urandom_range(0, pool_span() - 1));
				end else if ($urandom_range(0, 99) < 8) begin
					op = 1'($urandom_range(0, 1));
					idx = IDX_W'($urandom_range(0, 63));
				end else if (held.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
					op = OP_ALLOC;
					idx = IDX_W'($urandom_range(0, 63));
				end else begin
					op = OP_FREE;
					j = $urandom_range(0, held.size() - 1);
					idx = IDX_W'(held[j]);
					held.delete(j);
				end
				send_request(op, idx, 0, '0, got);
				if (op == OP_ALLOC && got.status == ST_OK)
					held.push_back(int'(got.index));
				sent++;
			end
			phase++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
